FILE: rtl/core/tprc_pkg.sv
// Shared types and constants for the timed PWM run controller.
`default_nettype none

package tprc_pkg;

  // Field widths
  localparam int unsigned TickW    = 32;
  localparam int unsigned DutyReqW = 8;
  localparam int unsigned ReloadW  = 16;
  localparam int unsigned PeriodW  = ReloadW + 1;
  localparam int unsigned CompareW = 17;
  localparam int unsigned StatusW  = 2;

  // Reload value after reset; the period is reload plus one
  localparam logic [ReloadW-1:0] ReloadReset = ReloadW'(999);

  // Duty is given in percent
  localparam int unsigned DutyScale = 100;

  // floor(x / DutyScale) as (x * RecipMul) >> RecipShift, exact for x < 2^23
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipW     = 24;
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((64'd1 << RecipShift) + 64'(DutyScale) - 64'd1) / 64'(DutyScale));

  // Run status codes
  typedef enum logic [StatusW-1:0] {
    ST_IDLE    = 2'd0,
    ST_RUNNING = 2'd1,
    ST_DONE    = 2'd2
  } run_status_e;

endpackage

`default_nettype wire

FILE: rtl/core/timed_pwm_run_controller.sv
// Timed PWM run controller: poll/reset requests in, status and PWM compare out.
`default_nettype none

// Takes one request per cycle while in_stall_o is low and gives one result per
// request via the result register once it is free. A request is captured in
// an input register together with period*duty (one multiplier); the next stage
// divides that product by 100 with a constant reciprocal multiply, compares the
// elapsed tick count against the run length and updates the run state and the
// result register at the same edge, so the following request already sees it.
// The reload register is written through its own port, always ready; a new
// period applies from the next run start.
module timed_pwm_run_controller #(
  parameter int unsigned DUTY_LIMIT = 100
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [tprc_pkg::ReloadW-1:0]       cfg_data_i,
  // request channel
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire                                cmd_i,
  input  wire  [tprc_pkg::DutyReqW-1:0]      duty_request_i,
  input  wire  [tprc_pkg::TickW-1:0]         run_length_ms_i,
  input  wire  [tprc_pkg::TickW-1:0]         now_ms_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [tprc_pkg::StatusW-1:0]       run_status_o,
  output logic [tprc_pkg::CompareW-1:0]      pwm_compare_o
);

  localparam int unsigned DutyW = $clog2(DUTY_LIMIT + 1);
  localparam int unsigned PdW   = tprc_pkg::PeriodW + DutyW;
  localparam int unsigned ScW   = PdW + tprc_pkg::RecipW;

  // ---------------------------------------------------------------------------
  // Period register (reload + 1), written from the config port
  logic [tprc_pkg::PeriodW-1:0] period_q, period_d;

  assign cfg_ready_o = 1'b1;
  assign period_d    = tprc_pkg::PeriodW'(cfg_data_i) + tprc_pkg::PeriodW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= tprc_pkg::PeriodW'(tprc_pkg::ReloadReset) + tprc_pkg::PeriodW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q <= period_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_fire, in_fire, out_fire;

  assign out_fire   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: clamp duty and form period * duty
  logic [DutyW-1:0]                duty_clamp;
  logic                            s1_cmd_q;
  logic [DutyW-1:0]                s1_duty_q;
  logic [tprc_pkg::TickW-1:0]      s1_len_q, s1_now_q;
  logic [PdW-1:0]                  s1_pd_q, s1_pd_d;

  assign duty_clamp = (duty_request_i > tprc_pkg::DutyReqW'(DUTY_LIMIT)) ?
                      DutyW'(DUTY_LIMIT) : DutyW'(duty_request_i);
  assign s1_pd_d    = PdW'(period_q) * PdW'(duty_clamp);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= cmd_i;
      s1_duty_q <= duty_clamp;
      s1_len_q  <= run_length_ms_i;
      s1_now_q  <= now_ms_i;
      s1_pd_q   <= s1_pd_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Run state update
  tprc_pkg::run_status_e          status_q, status_d;
  logic [DutyW-1:0]               sduty_q, sduty_d;
  logic [tprc_pkg::TickW-1:0]     slen_q, slen_d;
  logic [tprc_pkg::TickW-1:0]     start_q, start_d;
  logic [tprc_pkg::CompareW-1:0]  cmp_q, cmp_d;
  logic [ScW-1:0]                 pd_scaled;
  logic [tprc_pkg::CompareW-1:0]  cmp_cand;
  logic [tprc_pkg::TickW-1:0]     elapsed;
  logic                           restart;

  // divide by 100 through the reciprocal
  assign pd_scaled = ScW'(s1_pd_q) * ScW'(tprc_pkg::RecipMul);
  assign cmp_cand  = tprc_pkg::CompareW'(pd_scaled >> tprc_pkg::RecipShift);
  assign elapsed   = s1_now_q - start_q;
  assign restart   = (status_q == tprc_pkg::ST_IDLE) || (s1_duty_q != sduty_q) ||
                     (s1_len_q != slen_q);

  always_comb begin
    status_d = status_q;
    sduty_d  = sduty_q;
    slen_d   = slen_q;
    start_d  = start_q;
    cmp_d    = cmp_q;
    if (s1_cmd_q) begin
      // reset request: stop and forget the run
      status_d = tprc_pkg::ST_IDLE;
      sduty_d  = '0;
      slen_d   = '0;
      start_d  = '0;
      cmp_d    = '0;
    end else if (s1_duty_q == '0 || s1_len_q == '0) begin
      // nothing to run: stop, keep start tick
      status_d = tprc_pkg::ST_DONE;
      sduty_d  = s1_duty_q;
      slen_d   = s1_len_q;
      cmp_d    = '0;
    end else if (restart) begin
      // new run; length is nonzero so it cannot expire at once
      status_d = tprc_pkg::ST_RUNNING;
      sduty_d  = s1_duty_q;
      slen_d   = s1_len_q;
      start_d  = s1_now_q;
      cmp_d    = cmp_cand;
    end else if (status_q == tprc_pkg::ST_RUNNING && elapsed >= slen_q) begin
      // run time used up
      status_d = tprc_pkg::ST_DONE;
      cmp_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= tprc_pkg::ST_IDLE;
      sduty_q  <= '0;
      slen_q   <= '0;
      start_q  <= '0;
      cmp_q    <= '0;
    end else if (s1_fire) begin
      status_q <= status_d;
      sduty_q  <= sduty_d;
      slen_q   <= slen_d;
      start_q  <= start_d;
      cmp_q    <= cmp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  logic [tprc_pkg::StatusW-1:0]   res_status_q;
  logic [tprc_pkg::CompareW-1:0]  res_cmp_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_status_q <= status_d;
      res_cmp_q    <= cmp_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign run_status_o  = res_status_q;
  assign pwm_compare_o = res_cmp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_stopped_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != tprc_pkg::ST_RUNNING) |-> (cmp_q == '0))
    else $error("drive active while not running");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("request stalled with room in the pipeline");

  a_fire_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("processed request produced no result");

endmodule

`default_nettype wire
